FILE: src/best_fit_boundary_tag_allocator_top_macros.svh
// Assertion macros used by the best-fit allocator top level.
`ifndef BEST_FIT_BOUNDARY_TAG_ALLOCATOR_TOP_MACROS_SVH
`define BEST_FIT_BOUNDARY_TAG_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BFBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfba: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfba: next-cycle check failed");

`endif

FILE: src/bfba_pkg.sv
// Shared types, command codes and helpers for the best-fit allocator.
package bfba_pkg;

    localparam int TAG_W     = 32;
    localparam int WIDE_W    = 36;
    localparam int TAG_BYTES = 4;
    localparam int OVERHEAD  = 8;
    localparam int OP_W      = 4;

    localparam logic [OP_W-1:0] OP_NONE         = 4'd0;
    localparam logic [OP_W-1:0] OP_CLEAR        = 4'd1;
    localparam logic [OP_W-1:0] OP_LOAD         = 4'd2;
    localparam logic [OP_W-1:0] OP_WALK_RD      = 4'd3;
    localparam logic [OP_W-1:0] OP_WALK_EVAL    = 4'd4;
    localparam logic [OP_W-1:0] OP_ALLOC_WR     = 4'd5;
    localparam logic [OP_W-1:0] OP_FREE_RD_HDR  = 4'd6;
    localparam logic [OP_W-1:0] OP_FREE_CAP_HDR = 4'd7;
    localparam logic [OP_W-1:0] OP_FREE_CALC_R  = 4'd8;
    localparam logic [OP_W-1:0] OP_FREE_RD_R    = 4'd9;
    localparam logic [OP_W-1:0] OP_FREE_CAP_R   = 4'd10;
    localparam logic [OP_W-1:0] OP_FREE_RD_L    = 4'd11;
    localparam logic [OP_W-1:0] OP_FREE_CAP_L   = 4'd12;
    localparam logic [OP_W-1:0] OP_FREE_CALC    = 4'd13;
    localparam logic [OP_W-1:0] OP_FREE_WR      = 4'd14;
    localparam logic [OP_W-1:0] OP_RESULT       = 4'd15;

    typedef logic signed [TAG_W-1:0]  t_tag;
    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      step;
        logic            ok;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic range_ok;
        logic walk_done;
        logic found;
        logic split;
        logic has_r;
        logic has_l;
        logic fok;
        logic out_free;
    } t_status;

    function automatic logic [TAG_W-1:0] tag_mag(input t_tag t);
        logic [TAG_W-1:0] u;
        u = t;
        return t[TAG_W-1] ? (~u + TAG_W'(1)) : u;
    endfunction

endpackage

FILE: src/bfba_tag_mem.sv
// Byte pool in four interleaved banks, giving one 32-bit tag read or write per cycle.
module bfba_tag_mem #(
    parameter int POOL_BYTES = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rd_en,
    input  logic [$clog2(POOL_BYTES)-1:0]         i_rd_off,
    output logic [bfba_pkg::TAG_W-1:0]            o_rd_data,
    input  logic                                  i_wr_en,
    input  logic [$clog2(POOL_BYTES)-1:0]         i_wr_off,
    input  logic [bfba_pkg::TAG_W-1:0]            i_wr_data,
    input  logic                                  i_clr_en,
    input  logic [$clog2((POOL_BYTES+3)/4)-1:0]   i_clr_row
);
    import bfba_pkg::*;

    localparam int DEPTH = (POOL_BYTES + 3) / 4;
    localparam int IW    = $clog2(DEPTH);
    localparam logic [TAG_W-1:0] INIT_TAG = TAG_W'(POOL_BYTES - OVERHEAD);

    logic [7:0] r_q [4];
    logic [1:0] r_sh;
    logic [1:0] sel [4];

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [7:0]    r_mem [DEPTH];
        logic [1:0]    wr_j;
        logic [IW-1:0] rd_idx;
        logic [IW-1:0] w_idx;
        logic [7:0]    w_byte;
        logic          w_en;
        logic [31:0]   ca;
        logic [1:0]    tail;

        always_comb begin
            rd_idx = IW'(i_rd_off >> 2) + IW'(2'(k) < i_rd_off[1:0]);
            wr_j   = 2'(k) - i_wr_off[1:0];
            ca     = 32'({i_clr_row, 2'(k)});
            tail   = 2'(ca - 32'(POOL_BYTES - TAG_BYTES));
            w_en   = i_wr_en || i_clr_en;
            if (i_clr_en) begin
                w_idx = i_clr_row;
                if (ca < 32'(TAG_BYTES)) begin
                    w_byte = INIT_TAG[8*ca[1:0] +: 8];
                end else if (ca >= 32'(POOL_BYTES - TAG_BYTES) && ca < 32'(POOL_BYTES)) begin
                    w_byte = INIT_TAG[8*tail +: 8];
                end else begin
                    w_byte = 8'd0;
                end
            end else begin
                w_idx  = IW'(i_wr_off >> 2) + IW'(2'(k) < i_wr_off[1:0]);
                w_byte = i_wr_data[8*wr_j +: 8];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_mem[w_idx] <= w_byte;
            end
            if (i_rd_en) begin
                r_q[k] <= r_mem[rd_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_sh <= i_rd_off[1:0];
        end
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            sel[j] = r_sh + 2'(j);
            o_rd_data[8*j +: 8] = r_q[sel[j]];
        end
    end

endmodule

FILE: src/bfba_datapath.sv
// Datapath of the allocator: request registers, walk and merge arithmetic, pool and result.
module bfba_datapath #(
    parameter int POOL_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfba_pkg::t_cmd    i_cmd,
    output bfba_pkg::t_status o_status,
    input  logic              i_func,
    input  logic [11:0]       i_req_size,
    input  logic [11:0]       i_free_addr,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic              o_ok,
    output logic [11:0]       o_data_addr
);
    import bfba_pkg::*;

    localparam int DEPTH = (POOL_BYTES + 3) / 4;
    localparam int AW    = $clog2(POOL_BYTES);
    localparam int PW    = $clog2(POOL_BYTES + 1);
    localparam int IW    = $clog2(DEPTH);
    localparam t_wide POOL_W = t_wide'(POOL_BYTES);

    logic              r_func;
    logic [11:0]       r_size;
    logic [11:0]       r_o;
    logic [PW-1:0]     r_p;
    logic [PW-1:0]     r_best;
    logic [PW-1:0]     r_bsize;
    logic              r_found;
    logic [TAG_W-1:0]  r_a;
    t_wide             r_oa;
    t_wide             r_r;
    logic              r_has_r;
    t_tag              r_ls;
    t_tag              r_rs;
    t_wide             r_hdr;
    t_wide             r_ftr;
    t_wide             r_sz;
    logic [IW-1:0]     r_clr_row;
    logic              r_ovalid;
    logic              r_ok;
    logic [11:0]       r_addr;

    logic [TAG_W-1:0]  rd_data;
    logic              rd_en;
    logic [AW-1:0]     rd_off;
    logic              wr_en;
    logic [AW-1:0]     wr_off;
    logic [TAG_W-1:0]  wr_data;
    logic              clr_en;

    t_tag              t;
    logic [TAG_W-1:0]  mag;
    t_wide             w_end;
    logic              w_fits;
    logic              w_take;
    logic              split;
    t_wide             o_w;
    t_wide             a_w;
    t_wide             ls_w;
    t_wide             rs_w;
    t_wide             oa_sum;
    t_wide             n_hdr;
    t_wide             n_ftr;
    t_wide             n_sz;
    logic [TAG_W-1:0]  neg_size;
    logic [TAG_W-1:0]  neg_bsize;
    logic [TAG_W-1:0]  rest;
    logic [31:0]       best_w;

    bfba_tag_mem #(
        .POOL_BYTES(POOL_BYTES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_off  (rd_off),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_off  (wr_off),
        .i_wr_data (wr_data),
        .i_clr_en  (clr_en),
        .i_clr_row (r_clr_row)
    );

    always_comb begin
        t      = t_tag'(rd_data);
        mag    = tag_mag(t);
        w_end  = t_wide'(r_p) + t_wide'(mag) + t_wide'(OVERHEAD);
        w_fits = w_end <= POOL_W;
        w_take = w_fits && (t_wide'(t) >= t_wide'(r_size)) && (t_wide'(t) < t_wide'(r_bsize));
        split  = (32'(r_bsize) - 32'(r_size)) > 32'(OVERHEAD);

        o_w    = t_wide'(r_o);
        a_w    = t_wide'(r_a);
        ls_w   = t_wide'(r_ls);
        rs_w   = t_wide'(r_rs);
        oa_sum = o_w + a_w;

        if (r_ls > 0) begin
            n_hdr = o_w - t_wide'(12) - ls_w;
        end else begin
            n_hdr = o_w - t_wide'(TAG_BYTES);
        end
        if (r_rs > 0) begin
            n_ftr = r_oa + t_wide'(OVERHEAD) + rs_w;
        end else begin
            n_ftr = r_oa;
        end
        if (r_ls > 0 && r_rs > 0) begin
            n_sz = ls_w + a_w + rs_w + t_wide'(16);
        end else if (r_ls > 0) begin
            n_sz = ls_w + t_wide'(OVERHEAD) + a_w;
        end else if (r_rs > 0) begin
            n_sz = rs_w + t_wide'(OVERHEAD) + a_w;
        end else begin
            n_sz = a_w;
        end

        neg_size  = TAG_W'(0) - TAG_W'(r_size);
        neg_bsize = TAG_W'(0) - TAG_W'(r_bsize);
        rest      = TAG_W'(r_bsize) - TAG_W'(r_size) - TAG_W'(OVERHEAD);
        best_w    = 32'(r_best);
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_off  = '0;
        wr_en   = 1'b0;
        wr_off  = '0;
        wr_data = '0;
        clr_en  = 1'b0;
        case (i_cmd.op)
            OP_CLEAR: begin
                clr_en = 1'b1;
            end
            OP_WALK_RD: begin
                rd_en  = 1'b1;
                rd_off = AW'(r_p);
            end
            OP_FREE_RD_HDR: begin
                rd_en  = 1'b1;
                rd_off = AW'(32'(r_o) - 32'(TAG_BYTES));
            end
            OP_FREE_RD_R: begin
                rd_en  = 1'b1;
                rd_off = AW'(r_r);
            end
            OP_FREE_RD_L: begin
                rd_en  = 1'b1;
                rd_off = AW'(32'(r_o) - 32'(OVERHEAD));
            end
            OP_ALLOC_WR: begin
                wr_en = 1'b1;
                case (i_cmd.step)
                    2'd0: begin
                        wr_off  = AW'(best_w);
                        wr_data = split ? neg_size : neg_bsize;
                    end
                    2'd1: begin
                        if (split) begin
                            wr_off  = AW'(best_w + 32'(TAG_BYTES) + 32'(r_size));
                            wr_data = neg_size;
                        end else begin
                            wr_off  = AW'(best_w + 32'(TAG_BYTES) + 32'(r_bsize));
                            wr_data = neg_bsize;
                        end
                    end
                    2'd2: begin
                        wr_off  = AW'(best_w + 32'(OVERHEAD) + 32'(r_size));
                        wr_data = rest;
                    end
                    default: begin
                        wr_off  = AW'(best_w + 32'(TAG_BYTES) + 32'(r_bsize));
                        wr_data = rest;
                    end
                endcase
            end
            OP_FREE_WR: begin
                wr_en   = 1'b1;
                wr_off  = i_cmd.step[0] ? AW'(r_ftr) : AW'(r_hdr);
                wr_data = TAG_W'(r_sz);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_func  <= i_func;
                r_size  <= i_req_size;
                r_o     <= i_free_addr;
                r_p     <= '0;
                r_bsize <= PW'(POOL_BYTES);
                r_best  <= '0;
                r_found <= 1'b0;
                r_ls    <= '0;
                r_rs    <= '0;
            end
            OP_WALK_EVAL: begin
                if (w_fits) begin
                    r_p <= PW'(w_end);
                end else begin
                    r_p <= PW'(POOL_BYTES);
                end
                if (w_take) begin
                    r_best  <= r_p;
                    r_bsize <= PW'(mag);
                    r_found <= 1'b1;
                end
            end
            OP_FREE_CAP_HDR: begin
                r_a <= mag;
            end
            OP_FREE_CALC_R: begin
                r_oa    <= oa_sum;
                r_r     <= oa_sum + t_wide'(TAG_BYTES);
                r_has_r <= (oa_sum + t_wide'(OVERHEAD)) <= POOL_W;
            end
            OP_FREE_CAP_R: begin
                r_rs <= t;
            end
            OP_FREE_CAP_L: begin
                r_ls <= t;
            end
            OP_FREE_CALC: begin
                r_hdr <= n_hdr;
                r_ftr <= n_ftr;
                r_sz  <= n_sz;
            end
            OP_RESULT: begin
                r_ok   <= i_cmd.ok;
                r_addr <= (i_cmd.ok && !r_func) ? 12'(best_w + 32'(TAG_BYTES)) : 12'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cmd.op == OP_CLEAR) begin
                r_clr_row <= r_clr_row + IW'(1);
            end
            if (i_cmd.op == OP_RESULT) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.clr_last  = r_clr_row == IW'(DEPTH - 1);
        o_status.is_free   = r_func;
        o_status.range_ok  = (32'(r_o) >= 32'(TAG_BYTES)) && (32'(r_o) <= 32'(POOL_BYTES));
        o_status.walk_done = (32'(r_p) + 32'(TAG_BYTES)) > 32'(POOL_BYTES);
        o_status.found     = r_found;
        o_status.split     = split;
        o_status.has_r     = r_has_r;
        o_status.has_l     = 32'(r_o) >= 32'(OVERHEAD);
        o_status.fok       = !r_hdr[WIDE_W-1] && !r_ftr[WIDE_W-1]
                             && ((r_ftr + t_wide'(TAG_BYTES)) <= POOL_W);
        o_status.out_free  = !r_ovalid || !i_out_stall;
    end

    assign o_out_valid = r_ovalid;
    assign o_ok        = r_ok;
    assign o_data_addr = r_addr;

endmodule

FILE: src/bfba_ctrl.sv
// Controller state machine that sequences clearing, the best-fit walk and the merge on free.
module bfba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bfba_pkg::t_status i_status,
    output bfba_pkg::t_cmd    o_cmd
);
    import bfba_pkg::*;

    localparam logic [4:0] S_CLEAR    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_START    = 5'd2;
    localparam logic [4:0] S_WALK_RD  = 5'd3;
    localparam logic [4:0] S_WALK_EV  = 5'd4;
    localparam logic [4:0] S_ALLOC_WR = 5'd5;
    localparam logic [4:0] S_F_RD_H   = 5'd6;
    localparam logic [4:0] S_F_CAP_H  = 5'd7;
    localparam logic [4:0] S_F_CALC_R = 5'd8;
    localparam logic [4:0] S_F_RD_R   = 5'd9;
    localparam logic [4:0] S_F_CAP_R  = 5'd10;
    localparam logic [4:0] S_F_RD_L   = 5'd11;
    localparam logic [4:0] S_F_CAP_L  = 5'd12;
    localparam logic [4:0] S_F_CALC   = 5'd13;
    localparam logic [4:0] S_F_CHK    = 5'd14;
    localparam logic [4:0] S_F_WR     = 5'd15;
    localparam logic [4:0] S_DONE     = 5'd16;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic [1:0] r_step;
    logic [1:0] n_step;
    logic       r_ok;
    logic       n_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= 2'd0;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_ok    <= n_ok;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_ok       = r_ok;
        o_cmd.op   = OP_NONE;
        o_cmd.step = r_step;
        o_cmd.ok   = r_ok;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_START;
                end
            end
            S_START: begin
                n_step = 2'd0;
                if (!i_status.is_free) begin
                    n_state = S_WALK_RD;
                end else if (i_status.range_ok) begin
                    n_state = S_F_RD_H;
                end else begin
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_WALK_RD: begin
                if (!i_status.walk_done) begin
                    o_cmd.op = OP_WALK_RD;
                    n_state  = S_WALK_EV;
                end else if (i_status.found) begin
                    n_state = S_ALLOC_WR;
                end else begin
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_WALK_EV: begin
                o_cmd.op = OP_WALK_EVAL;
                n_state  = S_WALK_RD;
            end
            S_ALLOC_WR: begin
                o_cmd.op = OP_ALLOC_WR;
                if (r_step == (i_status.split ? 2'd3 : 2'd1)) begin
                    n_step  = 2'd0;
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            S_F_RD_H: begin
                o_cmd.op = OP_FREE_RD_HDR;
                n_state  = S_F_CAP_H;
            end
            S_F_CAP_H: begin
                o_cmd.op = OP_FREE_CAP_HDR;
                n_state  = S_F_CALC_R;
            end
            S_F_CALC_R: begin
                o_cmd.op = OP_FREE_CALC_R;
                n_state  = S_F_RD_R;
            end
            S_F_RD_R: begin
                if (i_status.has_r) begin
                    o_cmd.op = OP_FREE_RD_R;
                    n_state  = S_F_CAP_R;
                end else begin
                    n_state = S_F_RD_L;
                end
            end
            S_F_CAP_R: begin
                o_cmd.op = OP_FREE_CAP_R;
                n_state  = S_F_RD_L;
            end
            S_F_RD_L: begin
                if (i_status.has_l) begin
                    o_cmd.op = OP_FREE_RD_L;
                    n_state  = S_F_CAP_L;
                end else begin
                    n_state = S_F_CALC;
                end
            end
            S_F_CAP_L: begin
                o_cmd.op = OP_FREE_CAP_L;
                n_state  = S_F_CALC;
            end
            S_F_CALC: begin
                o_cmd.op = OP_FREE_CALC;
                n_state  = S_F_CHK;
            end
            S_F_CHK: begin
                n_step = 2'd0;
                if (i_status.fok) begin
                    n_state = S_F_WR;
                end else begin
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_F_WR: begin
                o_cmd.op = OP_FREE_WR;
                if (r_step == 2'd1) begin
                    n_step  = 2'd0;
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

FILE: src/best_fit_boundary_tag_allocator_top.sv
// Top level of the best-fit boundary-tag allocator: controller, datapath and checks.
//
// Requests arrive on the input channel (i_in_valid, o_in_stall) with an operation,
// a request size and a data offset to free. Each transfer yields exactly one result
// on the output channel (o_out_valid, i_out_stall): a success flag and, for a
// successful allocation, the offset of the data area.
// One request is in work at a time. An allocation walks the block list up to the
// pool end, reading one tag per block through the read port of the pool. A free
// reads up to three tags and writes two.
// The next request is taken in the cycle after its result is registered.
// After reset the pool is swept one row of four bytes per cycle, all (POOL_BYTES+3)/4
// rows (1024 for the default pool), leaving one free block across the whole
// pool; o_in_stall stays high throughout the sweep.
// A stalled result is held in the output register; a finished request waits for
// that register to empty before its own result is loaded.
`include "best_fit_boundary_tag_allocator_top_macros.svh"

module best_fit_boundary_tag_allocator_top #(
    parameter int POOL_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [11:0] i_req_size,
    input  logic [11:0] i_free_addr,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_ok,
    output logic [11:0] o_data_addr
);
    import bfba_pkg::*;

    t_cmd    cmd;
    t_status status;

    bfba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bfba_datapath #(
        .POOL_BYTES(POOL_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_func      (i_func),
        .i_req_size  (i_req_size),
        .i_free_addr (i_free_addr),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_ok        (o_ok),
        .o_data_addr (o_data_addr)
    );

    `BFBA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `BFBA_ASSERT_IMP(a_fail_addr_zero, i_clk, i_rst_n, o_out_valid && !o_ok, o_data_addr == 12'd0)
    `BFBA_ASSERT_IMP(a_result_from_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

FILE: dv/best_fit_boundary_tag_allocator_top_tb.sv
// Self-checking testbench for the best-fit boundary-tag allocator: directed and random requests.
module best_fit_boundary_tag_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfba_pkg::t_tag;
    import bfba_pkg::TAG_BYTES;
    import bfba_pkg::OVERHEAD;

    localparam int POOL_BYTES = 4096;
    localparam bit FUNC_ALLOC = 1'b0;
    localparam bit FUNC_FREE  = 1'b1;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES = 1100;

    typedef struct packed {
        bit        func;
        bit [11:0] size;
        bit [11:0] addr;
    } t_request;

    typedef struct packed {
        bit        ok;
        bit [11:0] addr;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_func = 1'b0;
    logic [11:0] i_req_size = '0;
    logic [11:0] i_free_addr = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_ok;
    logic [11:0] o_data_addr;

    logic [7:0] pool_mem [0:POOL_BYTES-1];
    t_request   request_q[$];
    t_reply     reply_q[$];
    bit [11:0]  live_q[$];
    bit [11:0]  freed_q[$];
    int         fault_count = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    bit         rx_hold = 1'b0;
    bit         hold_arm = 1'b0;

    best_fit_boundary_tag_allocator_top #(
        .POOL_BYTES(POOL_BYTES)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_func(i_func),
        .i_req_size(i_req_size),
        .i_free_addr(i_free_addr),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_ok(o_ok),
        .o_data_addr(o_data_addr)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fault_count < 40) begin
            $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
        end
        fault_count++;
    endtask

    function automatic longint tag_at(input longint off);
        t_tag t;
        t = {pool_mem[off+3], pool_mem[off+2], pool_mem[off+1], pool_mem[off]};
        return longint'(t);
    endfunction

    function automatic void put_tag(input longint off, input longint val);
        logic [31:0] v;
        v = val[31:0];
        pool_mem[off]   = v[7:0];
        pool_mem[off+1] = v[15:8];
        pool_mem[off+2] = v[23:16];
        pool_mem[off+3] = v[31:24];
    endfunction

    function automatic longint tag_size(input longint t);
        return (t < 0) ? -t : t;
    endfunction

    function automatic t_reply run_alloc(input longint want_size);
        longint p;
        longint best;
        longint best_len;
        longint t;
        longint stop_at;
        longint rest;
        bit     found;
        t_reply res;
        p = 0;
        best = 0;
        best_len = POOL_BYTES;
        found = 1'b0;
        res = '0;
        while (p + TAG_BYTES <= POOL_BYTES) begin
            t = tag_at(p);
            stop_at = p + tag_size(t) + OVERHEAD;
            if (stop_at > POOL_BYTES) break;
            if (t >= want_size && t < best_len) begin
                best = p;
                best_len = t;
                found = 1'b1;
            end
            p = stop_at;
        end
        if (!found) return res;
        if (best_len - want_size > OVERHEAD) begin
            rest = best_len - want_size - OVERHEAD;
            put_tag(best, -want_size);
            put_tag(best + TAG_BYTES + want_size, -want_size);
            put_tag(best + OVERHEAD + want_size, rest);
            put_tag(best + TAG_BYTES + best_len, rest);
        end else begin
            put_tag(best, -best_len);
            put_tag(best + TAG_BYTES + best_len, -best_len);
        end
        res.ok = 1'b1;
        res.addr = 12'(best + TAG_BYTES);
        return res;
    endfunction

    function automatic t_reply run_free(input longint o);
        longint a;
        longint hdr;
        longint ftr;
        longint sz;
        longint ls;
        longint rs;
        longint r;
        bit     has_l;
        bit     has_r;
        t_reply res;
        res = '0;
        ls = 0;
        rs = 0;
        has_l = 1'b0;
        has_r = 1'b0;
        if (o < TAG_BYTES || o > POOL_BYTES) return res;
        a = tag_size(tag_at(o - TAG_BYTES));
        r = o + a + TAG_BYTES;
        if (r + TAG_BYTES <= POOL_BYTES) begin
            has_r = 1'b1;
            rs = tag_at(r);
        end
        if (o >= OVERHEAD) begin
            has_l = 1'b1;
            ls = tag_at(o - OVERHEAD);
        end
        if (has_l && has_r && ls > 0 && rs > 0) begin
            hdr = o - 12 - ls;
            ftr = o + a + OVERHEAD + rs;
            sz = ls + a + rs + 16;
        end else if (has_l && ls > 0) begin
            hdr = o - 12 - ls;
            ftr = o + a;
            sz = ls + OVERHEAD + a;
        end else if (has_r && rs > 0) begin
            hdr = o - TAG_BYTES;
            ftr = o + a + OVERHEAD + rs;
            sz = rs + OVERHEAD + a;
        end else begin
            hdr = o - TAG_BYTES;
            ftr = o + a;
            sz = a;
        end
        if (hdr < 0 || ftr < 0 || ftr + TAG_BYTES > POOL_BYTES) return res;
        put_tag(hdr, sz);
        put_tag(ftr, sz);
        res.ok = 1'b1;
        return res;
    endfunction

    function automatic t_reply compute_reply(input t_request req);
        if (req.func == FUNC_ALLOC) begin
            return run_alloc(longint'(req.size));
        end
        return run_free(longint'(req.addr));
    endfunction

    // Request driver: predicts each transfer as it is accepted.
    always @(posedge i_clk) begin
        t_request cur;
        t_request nxt;
        t_reply   rep;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                cur.func = i_func;
                cur.size = i_req_size;
                cur.addr = i_free_addr;
                rep = compute_reply(cur);
                reply_q.push_back(rep);
                if (cur.func == FUNC_ALLOC && rep.ok) live_q.push_back(rep.addr);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = request_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_func      <= nxt.func;
                    i_req_size  <= nxt.size;
                    i_free_addr <= nxt.addr;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (reply_q.size() == 0) begin
                    report_mismatch("result with none expected, ok", o_ok, 0);
                end else begin
                    want = reply_q.pop_front();
                    if (o_ok !== want.ok) report_mismatch("ok", o_ok, want.ok);
                    if (o_data_addr !== want.addr) begin
                        report_mismatch("data_addr", o_data_addr, want.addr);
                    end
                end
            end
            i_out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
        end
    end

    initial begin
        wait (hold_arm);
        @(negedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send(input bit func, input bit [11:0] size, input bit [11:0] addr);
        t_request req;
        while (request_q.size() != 0) @(negedge i_clk);
        req.func = func;
        req.size = size;
        req.addr = addr;
        request_q.push_back(req);
    endtask

    task automatic req_alloc(input bit [11:0] size);
        send(FUNC_ALLOC, size, 12'($urandom_range(4095)));
    endtask

    task automatic req_free(input bit [11:0] addr);
        send(FUNC_FREE, 12'($urandom_range(4095)), addr);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (request_q.size() != 0 || i_in_valid || reply_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic bit [11:0] pick_size(input bit wide);
        int r;
        r = $urandom_range(99);
        if (r < 4 || (wide && r < 30)) return 12'($urandom_range(4095));
        if (r < 70) return 12'($urandom_range(64));
        if (r < 90) return 12'($urandom_range(512, 65));
        return 12'($urandom_range(2048, 513));
    endfunction

    task automatic random_request(input bit noisy);
        int        pick;
        int        idx;
        bit [11:0] a;
        pick = $urandom_range(99);
        if (noisy && pick < 25) begin
            req_free(12'($urandom_range(4095)));
        end else if (noisy && pick < 45 && freed_q.size() != 0) begin
            req_free(freed_q[$urandom_range(freed_q.size() - 1)]);
        end else if (live_q.size() != 0 && (pick < 40 || live_q.size() > 40)) begin
            idx = $urandom_range(live_q.size() - 1);
            a = live_q[idx];
            live_q.delete(idx);
            freed_q.push_back(a);
            if (freed_q.size() > 16) void'(freed_q.pop_front());
            req_free(a);
        end else begin
            req_alloc(pick_size(noisy));
        end
    endtask

    initial begin
        for (int k = 0; k < POOL_BYTES; k++) pool_mem[k] = 8'h00;
        put_tag(0, POOL_BYTES - OVERHEAD);
        put_tag(POOL_BYTES - TAG_BYTES, POOL_BYTES - OVERHEAD);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Whole-pool allocation, exact fit, splits, and merges with the right neighbour and with both neighbours.
        req_alloc(12'd4088);
        req_alloc(12'd1);
        req_free(12'd4);
        req_alloc(12'd4089);
        req_alloc(12'd4095);
        req_alloc(12'd4080);
        req_free(12'd4);
        req_alloc(12'd4079);
        req_free(12'd4);
        req_alloc(12'd0);
        req_alloc(12'd100);
        req_alloc(12'd100);
        req_alloc(12'd100);
        req_free(12'd0);
        req_free(12'd3);
        req_free(12'd4095);
        req_free(12'd12);
        req_free(12'd228);
        req_free(12'd120);
        req_free(12'd4);
        req_alloc(12'd4088);
        req_free(12'd4);
        wait_drained();
        live_q.delete();

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 61 : 0;
            rx_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 33 : 0;
            for (int n = 0; n < 440; n++) begin
                if (ph == 0 && n == 100) hold_arm = 1'b1;
                random_request(1'b0);
            end
            wait_drained();
        end

        tx_idle_pct = 33;
        rx_idle_pct = 61;
        for (int n = 0; n < 80; n++) random_request(1'b1);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (reply_q.size() != 0) report_mismatch("results missing", reply_q.size(), 0);
        if (fault_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

FILE: best_fit_boundary_tag_allocator_top.f
+incdir+src
src/bfba_pkg.sv
src/bfba_tag_mem.sv
src/bfba_datapath.sv
src/bfba_ctrl.sv
src/best_fit_boundary_tag_allocator_top.sv
dv/best_fit_boundary_tag_allocator_top_tb.sv
